// File: sv/sliding_median_filter_top_assert.svh
// Assertion macros for the sliding median filter.
// Each macro checks on the rising edge of clk and is disabled while arst_n is low.
`ifndef SLIDING_MEDIAN_FILTER_TOP_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_TOP_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define SMF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define SMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared constants and types of the sliding median filter: sample width,
// window geometry, queue sizing and the queue entry format.
// ----------------------------------------------------------------------------
package smf_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int HALF        = 2;
	localparam int SPAN        = 2 * HALF + 1;
	localparam int HIST_DEPTH  = SPAN - 1;
	localparam int CNT_W       = 3;
	localparam int JOB_W       = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// One classified sample: the window values and how many results it yields
	typedef struct packed {
		logic [SAMPLE_W-1:0]                  sample;
		logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] hist;
		logic [CNT_W-1:0]                     avail;
		logic [JOB_W-1:0]                     jobs_m1;
		logic                                 last;
	} entry_t;

	// Stage 1 of the median unit, watched at the top level
	typedef struct packed {
		logic             s1_valid;
		logic             s1_last;
		logic [CNT_W-1:0] s1_cnt;
	} back_status_t;

endpackage

// File: sv/smf_front.sv
// ----------------------------------------------------------------------------
// smf_front
// Accepts samples, keeps the frame history and classifies each sample into
// a queue entry that tells the back part how many medians to produce.
// ----------------------------------------------------------------------------
module smf_front import smf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  frame_end,
	input  logic                  queue_full,
	output logic                  push,
	output entry_t                push_entry,
	output logic [CNT_W-1:0]      seen_count
);

	logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] history_q;
	logic [CNT_W-1:0]                    seen_q;
	logic                                accept;

	assign accept     = sample_valid && !queue_full;
	assign seen_count = seen_q;

	// Classify: warm-up samples yield nothing, the frame end flushes
	always_comb begin
		push                  = accept && (frame_end || (seen_q >= CNT_W'(HALF)));
		push_entry.sample     = sample;
		push_entry.hist       = history_q;
		push_entry.avail      = seen_q + CNT_W'(1);
		push_entry.last       = frame_end;
		push_entry.jobs_m1    = '0;
		if (frame_end) begin
			if (seen_q >= CNT_W'(HALF))
				push_entry.jobs_m1 = JOB_W'(HALF);
			else
				push_entry.jobs_m1 = seen_q[JOB_W-1:0];
		end
	end

	// Advance the history, or drop it at the frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '0;
			seen_q    <= '0;
		end else if (accept) begin
			if (frame_end) begin
				history_q <= '0;
				seen_q    <= '0;
			end else begin
				history_q <= {history_q[HIST_DEPTH-2:0], sample};
				if (seen_q < CNT_W'(HIST_DEPTH))
					seen_q <= seen_q + CNT_W'(1);
			end
		end
	end

endmodule

// File: sv/smf_queue.sv
// ----------------------------------------------------------------------------
// smf_queue
// Short queue of classified samples between the front and the back part.
// ----------------------------------------------------------------------------
module smf_queue import smf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  entry_t            push_entry,
	input  logic              pop,
	output logic              head_valid,
	output entry_t            head,
	output logic              full,
	output logic [QCNT_W-1:0] count
);

	entry_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign count      = count_q;

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_entry;
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

// File: sv/smf_back.sv
// ----------------------------------------------------------------------------
// smf_back
// Expands each queue entry into one or more median jobs and computes them in
// a two-stage unit: pairwise compares, then rank count and select.
// ----------------------------------------------------------------------------
module smf_back import smf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  entry_t              head,
	output logic                pop,
	output logic [SAMPLE_W-1:0] median,
	output logic                last_of_frame,
	output logic                median_valid,
	input  logic                median_stall,
	output back_status_t        status
);

	logic [JOB_W-1:0]               job_q;
	logic                           started_q;
	logic [JOB_W-1:0]               job_cur;
	logic [CNT_W-1:0]               want;
	logic [CNT_W-1:0]               job_cnt;
	logic                           job_last;
	logic [SPAN-1:0][SAMPLE_W-1:0]  job_vals;
	logic [SPAN-1:0][SPAN-1:0]      prec;
	logic                           adv1;
	logic                           adv2;
	logic                           issue;

	logic                           valid_s1;
	logic                           last_s1;
	logic [CNT_W-1:0]               cnt_s1;
	logic [SPAN-1:0][SAMPLE_W-1:0]  vals_s1;
	logic [SPAN-1:0][SPAN-1:0]      prec_s1;

	logic                           valid_s2;
	logic                           last_s2;
	logic [SAMPLE_W-1:0]            median_s2;
	logic [SAMPLE_W-1:0]            med_sel;

	assign adv2  = !valid_s2 || !median_stall;
	assign adv1  = !valid_s1 || adv2;
	assign issue = head_valid && adv1;

	// Pick the job of the head entry: flush jobs count down to the last one
	always_comb begin
		job_cur  = started_q ? job_q : head.jobs_m1;
		want     = CNT_W'(job_cur) + CNT_W'(HALF + 1);
		if (head.last)
			job_cnt = (want < head.avail) ? want : head.avail;
		else
			job_cnt = head.avail;
		job_last = head.last && (job_cur == '0);
		pop      = issue && (job_cur == '0);
		job_vals[0] = head.sample;
		for (int i = 1; i < SPAN; i++)
			job_vals[i] = head.hist[i-1];
	end

	// Pairwise order: prec[k][i] means element k sorts ahead of element i
	always_comb begin
		prec = '0;
		for (int k = 0; k < SPAN; k++) begin
			for (int i = 0; i < SPAN; i++) begin
				if (k < i)
					prec[k][i] = (job_vals[k] <= job_vals[i]);
				else if (k > i)
					prec[k][i] = (job_vals[k] < job_vals[i]);
			end
		end
	end

	// Track the job counter of the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q     <= '0;
			started_q <= 1'b0;
		end else if (issue) begin
			if (job_cur == '0) begin
				started_q <= 1'b0;
			end else begin
				started_q <= 1'b1;
				job_q     <= job_cur - JOB_W'(1);
			end
		end
	end

	// Stage 1: hold compares and window values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv1)
			valid_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1 <= job_last;
			cnt_s1  <= job_cnt;
			vals_s1 <= job_vals;
			prec_s1 <= prec;
		end
	end

	// Select the element whose rank is cnt/2 among the active ones
	always_comb begin
		logic [CNT_W-1:0] rank;
		med_sel = '0;
		for (int i = 0; i < SPAN; i++) begin
			rank = '0;
			for (int k = 0; k < SPAN; k++) begin
				if ((k != i) && (CNT_W'(k) < cnt_s1) && prec_s1[k][i])
					rank = rank + CNT_W'(1);
			end
			if ((CNT_W'(i) < cnt_s1) && (rank == (cnt_s1 >> 1)))
				med_sel = med_sel | vals_s1[i];
		end
	end

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			median_s2 <= med_sel;
			last_s2   <= last_s1;
		end
	end

	assign median          = median_s2;
	assign last_of_frame   = last_s2;
	assign median_valid    = valid_s2;
	assign status.s1_valid = valid_s1;
	assign status.s1_last  = last_s1;
	assign status.s1_cnt   = cnt_s1;

endmodule

// File: sv/sliding_median_filter_top.sv
// After warm-up, a sample passes the queue, stage 1 and stage 2 to its median beat.
// Throughput: one sample per cycle unless the queue is full; a frame-end sample
// yields up to 3 beats, one per cycle unless stalled, all through the single median
// unit of the back part. A 4-entry queue between front and back absorbs flush beats.
// Reset (arst_n low): history, sample count, queue and pipeline valids clear.
// ----------------------------------------------------------------------------
// sliding_median_filter_top
// Five-tap sliding median over framed distance samples, with clipped windows
// at the frame edges and an upper median for even counts.
// ----------------------------------------------------------------------------
`include "sliding_median_filter_top_assert.svh"

module sliding_median_filter_top import smf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                frame_end,
	output logic                median_valid,
	input  logic                median_stall,
	output logic [SAMPLE_W-1:0] median,
	output logic                last_of_frame
);

	logic               push;
	entry_t             push_entry;
	logic               pop;
	logic               head_valid;
	entry_t             head;
	logic               full;
	logic [QCNT_W-1:0]  q_count;
	logic [CNT_W-1:0]   seen_count;
	back_status_t       back_status;
	logic               in_beat;
	logic               s1_mid;

	assign sample_stall = full;

	smf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample       (sample),
		.frame_end    (frame_end),
		.queue_full   (full),
		.push         (push),
		.push_entry   (push_entry),
		.seen_count   (seen_count)
	);

	smf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.full       (full),
		.count      (q_count)
	);

	smf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.median        (median),
		.last_of_frame (last_of_frame),
		.median_valid  (median_valid),
		.median_stall  (median_stall),
		.status        (back_status)
	);

	// Qualifiers for the checks below
	assign in_beat = sample_valid && !sample_stall;
	assign s1_mid  = back_status.s1_valid && !back_status.s1_last;

	// A frame end always queues its flush work
	`SMF_ASSERT_NEXT(a_flush_queued, in_beat && frame_end, q_count != '0, "frame end not queued")

	// A frame end restarts the history count
	`SMF_ASSERT_NEXT(a_frame_restart, in_beat && frame_end, seen_count == '0, "count not cleared")

	// A median that is not the frame's last spans at least two samples
	`SMF_ASSERT_SAME(a_min_window, s1_mid, back_status.s1_cnt >= CNT_W'(HALF), "window too short")

endmodule
